[hdl/flmtc_pkg.sv]
// Shared types, constants and codes for the trace classifier.
package flmtc_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 32;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      VERDICT_NOT_SURE   = 3'd0,
      VERDICT_QUEUE      = 3'd1,
      VERDICT_STACK      = 3'd2,
      VERDICT_PRIORITY   = 3'd3,
      VERDICT_IMPOSSIBLE = 3'd4
   } verdict_type;

   typedef struct packed {
      logic               command;
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic       could_be_queue;
      logic       could_be_stack;
      logic       could_be_priority;
      logic       overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DN_SWAP,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_item;     // capture incoming item
      logic push_write;    // write fifo tail, stack top, heap leaf; count up
      logic push_drop;     // set overflow
      logic up_read;       // write cursor key at cursor, read its parent
      logic up_swap;       // move parent down into cursor slot, move up
      logic pop_read;      // read fifo head, stack top, heap root and heap last
      logic pop_check;     // compare heads, move last to root, count down
      logic pop_empty;     // clear all flags
      logic dn_read;       // read both children
      logic dn_swap;       // write cursor key into larger child, move down
      logic finish;        // present verdict, reset trace state
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic cmd_pop;
      logic last;
      logic full;
      logic empty;
      logic at_root;
      logic up_go;         // parent smaller than cursor key
      logic dn_has_child;
      logic dn_go;         // larger child exceeds cursor key
   } sts_type;

endpackage

[hdl/flmtc_ram.sv]
// Generic single-port-write, dual-read RAM with registered read data.
module flmtc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

[hdl/flmtc_ctrl.sv]
// Sequencer for push, pop, heap sift and end of trace.
module flmtc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  flmtc_pkg::sts_type sts,
   output flmtc_pkg::ctl_type ctl
);
   import flmtc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            // hold input while an earlier verdict still waits
            req_stall = rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               ctl.load_item = 1'b1;
               state_in      = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (sts.cmd_pop) begin
               if (sts.empty) begin
                  ctl.pop_empty = 1'b1;
                  state_in      = sts.last ? ST_DONE : ST_IDLE;
               end else begin
                  state_in = ST_POP_RD;
               end
            end else if (sts.full) begin
               ctl.push_drop = 1'b1;
               state_in      = sts.last ? ST_DONE : ST_IDLE;
            end else begin
               ctl.push_write = 1'b1;
               state_in       = ST_UP_RD;
            end
         end
         ST_UP_RD: begin
            ctl.up_read = 1'b1;
            if (sts.at_root) begin
               state_in = sts.last ? ST_DONE : ST_IDLE;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (sts.up_go) begin
               ctl.up_swap = 1'b1;
               state_in    = ST_UP_RD;
            end else begin
               state_in = sts.last ? ST_DONE : ST_IDLE;
            end
         end
         ST_POP_RD: begin
            ctl.pop_read = 1'b1;
            state_in     = ST_POP_CMP;
         end
         ST_POP_CMP: begin
            ctl.pop_check = 1'b1;
            state_in      = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (sts.dn_has_child) begin
               ctl.dn_read = 1'b1;
               state_in    = ST_DN_CMP;
            end else begin
               state_in = sts.last ? ST_DONE : ST_IDLE;
            end
         end
         ST_DN_CMP: begin
            state_in = sts.dn_go ? ST_DN_SWAP : (sts.last ? ST_DONE : ST_IDLE);
         end
         ST_DN_SWAP: begin
            ctl.dn_swap = 1'b1;
            state_in    = ST_DN_RD;
         end
         ST_DONE: begin
            ctl.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> state_ff == ST_IDLE)
      else $error("verdict raised outside idle");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == ST_IDLE && !rsp_valid_ff)
      else $error("item taken while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE && rsp_valid)
      else $error("done did not present verdict");
endmodule

[hdl/flmtc_dp.sv]
// Stores, heap cursor, flags and verdict register.
module flmtc_dp #(
   parameter int CAPACITY   = flmtc_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = flmtc_pkg::VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  flmtc_pkg::req_type req_data,
   input  flmtc_pkg::ctl_type ctl,
   output flmtc_pkg::sts_type sts,
   output flmtc_pkg::rsp_type rsp_data
);
   import flmtc_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic                  cmd_ff, last_ff;
   logic [AW-1:0]         head_ff;
   logic [CW-1:0]         count_ff;
   logic [2:0]            flags_ff;
   logic                  ovf_ff;
   logic [AW-1:0]         cur_ff;
   logic [CW-1:0]         hsize_ff;
   logic [VALUE_BITS-1:0] cur_key_ff;
   rsp_type               rsp_ff;

   logic [VALUE_BITS-1:0] fifo_rd, stack_rd, heap_a, heap_b, unused_f, unused_s;
   logic [AW-1:0]         fifo_wa, fifo_ra, stack_wa, stack_ra, heap_wa, heap_ra, heap_rb;
   logic [CW:0]           tail_w;
   logic [VALUE_BITS-1:0] heap_wd;
   logic                  fifo_we, stack_we, heap_we;
   logic [CW:0]           left_w;
   logic [AW-1:0]         parent, left_c, right_c;
   logic                  right_ok;
   logic [AW-1:0]         best_ff;
   logic [VALUE_BITS-1:0] big_key;
   logic [AW-1:0]         big_idx;
   logic                  dn_rd_d_ff;
   logic [VALUE_BITS-1:0] sv;
   logic [2:0]            fsum;
   logic [2:0]            verdict;

   // offset-binary key: value truncated or sign-extended to VALUE_BITS, sign bit flipped
   always_comb begin
      sv = VALUE_BITS'(req_data.value);
      if (VALUE_BITS > 32 && req_data.value[31]) begin
         sv = ~VALUE_BITS'(~req_data.value);
      end
      key_in = sv ^ (VALUE_BITS'(1) << (VALUE_BITS - 1));
   end

   assign parent   = AW'((cur_ff - AW'(1)) >> 1);
   assign left_w   = (CW + 1)'({cur_ff, 1'b1});
   assign left_c   = AW'(left_w);
   assign right_c  = AW'(left_w + (CW + 1)'(1));
   assign right_ok = (left_w + (CW + 1)'(1)) < (CW + 1)'(hsize_ff);

   // datapath writes: push puts key at tails; sift moves go through the heap port
   always_comb begin
      tail_w   = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      if (tail_w >= (CW + 1)'(CAPACITY)) begin
         tail_w = tail_w - (CW + 1)'(CAPACITY);
      end
      fifo_we  = ctl.push_write;
      fifo_wa  = AW'(tail_w);
      stack_we = ctl.push_write;
      stack_wa = AW'(count_ff);
      fifo_ra  = head_ff;
      stack_ra = AW'(count_ff - CW'(1));
      heap_we  = 1'b0;
      heap_wa  = AW'(count_ff);
      heap_wd  = key_ff;
      heap_ra  = parent;
      heap_rb  = AW'(count_ff - CW'(1));
      if (ctl.push_write) begin
         heap_we = 1'b1;
      end else if (ctl.up_read) begin
         heap_we = 1'b1;
         heap_wa = cur_ff;
         heap_wd = cur_key_ff;
      end else if (ctl.up_swap) begin
         heap_we = 1'b1;
         heap_wa = cur_ff;
         heap_wd = heap_a;
      end else if (ctl.pop_check) begin
         heap_we = 1'b1;
         heap_wa = '0;
         heap_wd = heap_b;
      end else if (dn_rd_d_ff && big_key > cur_key_ff) begin
         // larger child moves up into the cursor slot
         heap_we = 1'b1;
         heap_wa = cur_ff;
         heap_wd = big_key;
      end else if (ctl.dn_swap) begin
         heap_we = 1'b1;
         heap_wa = best_ff;
         heap_wd = cur_key_ff;
      end
      if (ctl.pop_read) begin
         heap_ra = '0;
      end else if (ctl.dn_read) begin
         heap_ra = left_c;
         heap_rb = right_ok ? right_c : left_c;
      end
   end

   flmtc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_fifo (
      .clock(clock), .wr_en(fifo_we), .wr_addr(fifo_wa), .wr_data(key_ff),
      .rd_addr_a(fifo_ra), .rd_data_a(fifo_rd), .rd_addr_b(fifo_ra), .rd_data_b(unused_f));
   flmtc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_stack (
      .clock(clock), .wr_en(stack_we), .wr_addr(stack_wa), .wr_data(key_ff),
      .rd_addr_a(stack_ra), .rd_data_a(stack_rd), .rd_addr_b(stack_ra), .rd_data_b(unused_s));
   flmtc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
      .rd_addr_a(heap_ra), .rd_data_a(heap_a), .rd_addr_b(heap_rb), .rd_data_b(heap_b));

   always_comb begin
      big_key = heap_a;
      big_idx = left_c;
      if (right_ok && heap_b > heap_a) begin
         big_key = heap_b;
         big_idx = right_c;
      end
   end

   always_comb begin
      fsum = 3'(flags_ff[0]) + 3'(flags_ff[1]) + 3'(flags_ff[2]);
      if (fsum >= 3'd2)    verdict = VERDICT_NOT_SURE;
      else if (flags_ff[0]) verdict = VERDICT_QUEUE;
      else if (flags_ff[1]) verdict = VERDICT_STACK;
      else if (flags_ff[2]) verdict = VERDICT_PRIORITY;
      else                  verdict = VERDICT_IMPOSSIBLE;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         key_ff  <= key_in;
         cmd_ff  <= req_data.command;
         last_ff <= req_data.last;
      end
      if (ctl.push_write) begin
         cur_ff     <= AW'(count_ff);
         cur_key_ff <= key_ff;
      end
      if (ctl.up_swap) begin
         cur_ff <= parent;
      end
      if (ctl.pop_check) begin
         cur_ff     <= '0;
         cur_key_ff <= heap_b;
         hsize_ff   <= count_ff - CW'(1);
      end
      // sample children in the cycle after the read
      if (dn_rd_d_ff) begin
         best_ff <= big_idx;
      end
      if (ctl.dn_swap) begin
         cur_ff <= best_ff;
      end
      if (ctl.finish) begin
         rsp_ff.verdict           <= verdict;
         rsp_ff.could_be_queue    <= flags_ff[0];
         rsp_ff.could_be_stack    <= flags_ff[1];
         rsp_ff.could_be_priority <= flags_ff[2];
         rsp_ff.overflowed        <= ovf_ff;
      end
   end

   // children are on the read ports the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         dn_rd_d_ff <= 1'b0;
      end else begin
         dn_rd_d_ff <= ctl.dn_read;
      end
   end

   // trace state
   always_ff @(posedge clock) begin
      if (reset || ctl.finish) begin
         head_ff  <= '0;
         count_ff <= '0;
         flags_ff <= 3'b111;
         ovf_ff   <= 1'b0;
      end else begin
         if (ctl.push_write) count_ff <= count_ff + CW'(1);
         if (ctl.push_drop)  ovf_ff   <= 1'b1;
         if (ctl.pop_empty)  flags_ff <= 3'b000;
         if (ctl.pop_check) begin
            flags_ff <= flags_ff & {heap_a == key_ff, stack_rd == key_ff, fifo_rd == key_ff};
            head_ff  <= AW'((CW + 1)'(head_ff) + 1 == (CW + 1)'(CAPACITY) ? 0 :
                            (CW + 1)'(head_ff) + 1);
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   assign sts.cmd_pop      = cmd_ff;
   assign sts.last         = last_ff;
   assign sts.full         = count_ff >= CAP_C;
   assign sts.empty        = count_ff == '0;
   assign sts.at_root      = cur_ff == '0;
   assign sts.up_go        = heap_a < cur_key_ff;
   assign sts.dn_has_child = left_w < (CW + 1)'(hsize_ff);
   assign sts.dn_go        = big_key > cur_key_ff;
   assign rsp_data         = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("element count beyond capacity");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> count_ff == '0 && flags_ff == 3'b111 && !ovf_ff)
      else $error("trace state not cleared");
   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      ctl.pop_empty && !ctl.finish |=> flags_ff == 3'b000)
      else $error("empty pop kept a flag");
endmodule

[hdl/fifo_lifo_maxheap_trace_classifier.sv]
// Top level of the queue / stack / priority-queue trace classifier.
// Each item is a push or a pop of a signed value; pushes go into a FIFO, a LIFO and a
// max-heap held in three RAMs of CAPACITY entries, pops are checked against each head.
// An item is taken only in idle, and the next one waits until it is through. A dropped
// push or a pop on an empty trace touches no store; a push writes all three stores and
// then sifts the new key up, a read and a compare per heap level, until it reaches the
// root or a parent that is not smaller; a pop reads and checks the heads, moves the last
// heap key to the root and sifts it down, a read, a compare and a swap per level. Each
// sift goes through the single write port of the heap RAM. An item marked last then
// passes through a done state, and the verdict is held on rsp_ until taken; no new item
// is accepted while it waits. No clearing pass after reset.
module fifo_lifo_maxheap_trace_classifier #(
   parameter int CAPACITY   = flmtc_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = flmtc_pkg::VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  flmtc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output flmtc_pkg::rsp_type rsp_data
);
   import flmtc_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequence the item
   flmtc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .ctl(ctl));

   // hold stores and flags
   flmtc_dp #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .ctl(ctl), .sts(sts), .rsp_data(rsp_data));
endmodule

[verif/tb_fifo_lifo_maxheap_trace_classifier.sv]
// Testbench for the queue / stack / priority-queue trace classifier.
`timescale 1ns / 1ps

module tb_fifo_lifo_maxheap_trace_classifier;
   import flmtc_pkg::*;

   localparam int CAP = CAPACITY_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   fifo_lifo_maxheap_trace_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state: the three stores, kept as signed values.
   logic signed [31:0] fifo_mem [CAP];
   logic signed [31:0] stack_mem [CAP];
   logic signed [31:0] heap_mem [CAP];
   int                 q_head;
   int                 n_elems;
   logic [2:0]         flags;
   logic               ovf;

   rsp_type verdict_q [$];
   int      errors = 0;
   bit      hold_off = 1'b0;

   // Directed rows; the known verdict is checked on top of the predictor.
   typedef struct {
      req_type     item;
      bit          has_known;
      rsp_type     known;
   } row_type;

   function automatic rsp_type mk_rsp(verdict_type v, logic q, logic s, logic p, logic o);
      rsp_type r;
      r.verdict = v;
      r.could_be_queue = q;
      r.could_be_stack = s;
      r.could_be_priority = p;
      r.overflowed = o;
      return r;
   endfunction

   function automatic req_type mk_req(cmd_type c, logic signed [31:0] v, logic l);
      req_type r;
      r.command = c;
      r.value = v;
      r.last = l;
      return r;
   endfunction

   task automatic clear_trace();
      q_head = 0;
      n_elems = 0;
      flags = 3'b111;
      ovf = 1'b0;
   endtask

   // Apply one item to the classifier model; queue a verdict when it ends the trace.
   task automatic classify_item(req_type it);
      int         i, p, l, best, m;
      logic signed [31:0] t;
      rsp_type    r;
      int         cnt;
      if (it.command == CMD_PUSH) begin
         if (n_elems >= CAP) begin
            ovf = 1'b1;
         end else begin
            fifo_mem[(q_head + n_elems) % CAP] = it.value;
            stack_mem[n_elems] = it.value;
            i = n_elems;
            heap_mem[i] = it.value;
            while (i > 0) begin
               p = (i - 1) / 2;
               if (heap_mem[p] >= heap_mem[i]) break;
               t = heap_mem[p]; heap_mem[p] = heap_mem[i]; heap_mem[i] = t;
               i = p;
            end
            n_elems++;
         end
      end else if (n_elems == 0) begin
         flags = 3'b000;
      end else begin
         if (fifo_mem[q_head] != it.value) flags[0] = 1'b0;
         if (stack_mem[n_elems - 1] != it.value) flags[1] = 1'b0;
         if (heap_mem[0] != it.value) flags[2] = 1'b0;
         m = n_elems - 1;
         heap_mem[0] = heap_mem[m];
         i = 0;
         forever begin
            l = 2 * i + 1;
            if (l >= m) break;
            best = l;
            if (l + 1 < m && heap_mem[l + 1] > heap_mem[l]) best = l + 1;
            if (heap_mem[best] <= heap_mem[i]) break;
            t = heap_mem[best]; heap_mem[best] = heap_mem[i]; heap_mem[i] = t;
            i = best;
         end
         q_head = (q_head + 1) % CAP;
         n_elems--;
      end
      if (it.last) begin
         cnt = flags[0] + flags[1] + flags[2];
         r.verdict = (cnt >= 2) ? VERDICT_NOT_SURE :
                     flags[0] ? VERDICT_QUEUE :
                     flags[1] ? VERDICT_STACK :
                     flags[2] ? VERDICT_PRIORITY : VERDICT_IMPOSSIBLE;
         r.could_be_queue = flags[0];
         r.could_be_stack = flags[1];
         r.could_be_priority = flags[2];
         r.overflowed = ovf;
         verdict_q.push_back(r);
         clear_trace();
      end
   endtask

   // Offer one item and hold it until the block takes it.
   task automatic send_item(req_type it);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      classify_item(it);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Send with burst/gap pacing: after each item, maybe drop valid for a while.
   task automatic paced_send(req_type it);
      send_item(it);
      if ($urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 6));
   endtask

   function automatic logic signed [31:0] rand_val(int pool);
      if (pool > 0) return $signed($urandom_range(0, pool - 1)) - pool / 2;
      return $urandom();
   endfunction

   // One random trace: mostly well-formed for one kind, with some noise.
   task automatic random_trace(int len);
      int   kind, k, j, n;
      logic signed [31:0] vals [$];
      logic signed [31:0] v;
      int   pool;
      kind = $urandom_range(0, 4);
      pool = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 40);
      vals = {};
      for (k = 0; k < len; k++) begin
         bit lst;
         lst = (k == len - 1);
         if (vals.size() == 0 || $urandom_range(0, 1) == 0) begin
            v = rand_val(pool);
            vals.push_back(v);
            paced_send(mk_req(CMD_PUSH, v, lst));
         end else begin
            case (kind)
               0: v = vals.pop_front();
               1: v = vals.pop_back();
               2: begin
                  n = 0;
                  for (j = 1; j < vals.size(); j++) if (vals[j] > vals[n]) n = j;
                  v = vals[n];
                  vals.delete(n);
               end
               default: begin
                  v = ($urandom_range(0, 1) == 0) ? rand_val(pool) : vals[0];
                  void'(vals.pop_front());
               end
            endcase
            if ($urandom_range(0, 30) == 0) v = rand_val(pool);
            paced_send(mk_req(CMD_POP, v, lst));
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Receiver: own stall pattern, plus one long hold-off window.
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else begin
            mode = $urandom_range(0, 99);
            rsp_stall <= (mode < 30);
         end
      end
   end

   // Check each verdict against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("unexpected verdict %p", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = verdict_q.pop_front();
            if (rsp_data.verdict !== e.verdict) begin
               $error("verdict exp %0d got %0d", e.verdict, rsp_data.verdict); errors++;
            end
            if (rsp_data.could_be_queue !== e.could_be_queue) begin
               $error("could_be_queue exp %0b got %0b", e.could_be_queue,
                      rsp_data.could_be_queue); errors++;
            end
            if (rsp_data.could_be_stack !== e.could_be_stack) begin
               $error("could_be_stack exp %0b got %0b", e.could_be_stack,
                      rsp_data.could_be_stack); errors++;
            end
            if (rsp_data.could_be_priority !== e.could_be_priority) begin
               $error("could_be_priority exp %0b got %0b", e.could_be_priority,
                      rsp_data.could_be_priority); errors++;
            end
            if (rsp_data.overflowed !== e.overflowed) begin
               $error("overflowed exp %0b got %0b", e.overflowed, rsp_data.overflowed);
               errors++;
            end
         end
      end
   end

   // Stimulus: directed table, overflow trace, hold-off, then random traces.
   initial begin
      row_type rows [$];
      int      k, sent;
      clear_trace();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pop on empty trace, ending it: impossible.
      rows.push_back('{mk_req(CMD_POP, 32'sd0, 1'b1), 1'b1,
                       mk_rsp(VERDICT_IMPOSSIBLE, 0, 0, 0, 0)});
      // Lone push ending the trace: not sure.
      rows.push_back('{mk_req(CMD_PUSH, 32'sh7fffffff, 1'b1), 1'b1,
                       mk_rsp(VERDICT_NOT_SURE, 1, 1, 1, 0)});
      // Extremes: push min then max, pop max: stack and priority fit.
      rows.push_back('{mk_req(CMD_PUSH, 32'sh80000000, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_PUSH, 32'sh7fffffff, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_POP, 32'sh7fffffff, 1'b1), 1'b1,
                       mk_rsp(VERDICT_NOT_SURE, 0, 1, 1, 0)});
      // Queue only: push 1, 5, pop 1.
      rows.push_back('{mk_req(CMD_PUSH, 32'sd1, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_PUSH, 32'sd5, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_POP, 32'sd1, 1'b1), 1'b1,
                       mk_rsp(VERDICT_QUEUE, 1, 0, 0, 0)});
      // Stack only: push 5, 1, pop 1.
      rows.push_back('{mk_req(CMD_PUSH, 32'sd5, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_PUSH, 32'sd1, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_POP, 32'sd1, 1'b1), 1'b1,
                       mk_rsp(VERDICT_STACK, 0, 1, 0, 0)});
      // Priority only: push -3, 9, -1, pop 9.
      rows.push_back('{mk_req(CMD_PUSH, -32'sd3, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_PUSH, 32'sd9, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_PUSH, -32'sd1, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_POP, 32'sd9, 1'b1), 1'b1,
                       mk_rsp(VERDICT_PRIORITY, 0, 0, 1, 0)});
      // Mixed pops then pop past empty, checked by the predictor.
      rows.push_back('{mk_req(CMD_PUSH, -32'sd1, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_POP, -32'sd1, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_POP, 32'sh55aa55aa, 1'b0), 1'b0, '0});
      rows.push_back('{mk_req(CMD_PUSH, 32'shaa55aa55, 1'b1), 1'b0, '0});

      foreach (rows[i]) begin
         send_item(rows[i].item);
         if (rows[i].has_known && verdict_q[$] != rows[i].known) begin
            $error("directed row %0d: predictor disagrees with table", i);
            errors++;
         end
      end
      wait_drained();

      // Fill past capacity: overflow, then the block stalls on the long hold-off.
      hold_off = 1'b1;
      for (k = 0; k < CAP + 3; k++)
         send_item(mk_req(CMD_PUSH, $urandom(), 1'b0));
      send_item(mk_req(CMD_POP, fifo_mem[q_head], 1'b1));
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            // keep offering while the verdict is held back
            send_item(mk_req(CMD_PUSH, 32'sd4, 1'b0));
            send_item(mk_req(CMD_POP, 32'sd4, 1'b1));
         end
      join
      wait_drained();

      sent = 0;
      while (sent < 850) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         random_trace(k);
         sent += k;
         if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(5, 30));
      end
      req_valid <= 1'b0;
      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[fifo_lifo_maxheap_trace_classifier.f]
hdl/flmtc_pkg.sv
hdl/flmtc_ram.sv
hdl/flmtc_ctrl.sv
hdl/flmtc_dp.sv
hdl/fifo_lifo_maxheap_trace_classifier.sv
verif/tb_fifo_lifo_maxheap_trace_classifier.sv
